// ----- rtl/inmf_pkg.sv -----
// Shared types and constants for the impulse-noise neighbor-mean filter.
package inmf_pkg;

    localparam int PIXEL_BITS  = 8;
    localparam int ROW_BITS    = 12;
    localparam int HEIGHT_BITS = 13;
    localparam int FWIDTH_BITS = 12;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MIN_SIZE    = 3;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;
    localparam int SUM_BITS    = PIXEL_BITS + 3;

    localparam logic [FWIDTH_BITS-1:0] WIDTH_RESET  = FWIDTH_BITS'(1024);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(682);
    localparam logic [PIXEL_BITS-1:0]  DARK_RESET   = '0;
    localparam logic [PIXEL_BITS-1:0]  BRIGHT_RESET = '1;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_DARK_LEVEL   = 2'd2,
        REG_BRIGHT_LEVEL = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [FWIDTH_BITS-1:0] frame_width;
        logic [HEIGHT_BITS-1:0] frame_height;
        logic [PIXEL_BITS-1:0]  dark_level;
        logic [PIXEL_BITS-1:0]  bright_level;
    } cfg_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_in;
        logic                  frame_start;
    } in_word_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_out;
        logic                  replaced;
        logic                  frame_last;
    } out_word_t;

endpackage

// ----- rtl/inmf_regs.sv -----
// Configuration register bank on an APB-style port.
module inmf_regs
    import inmf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t       cfg_reg;
    reg_index_t index;
    logic       wr_en;

    assign index  = reg_index_t'(paddr[ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= WIDTH_RESET;
            cfg_reg.frame_height <= HEIGHT_RESET;
            cfg_reg.dark_level   <= DARK_RESET;
            cfg_reg.bright_level <= BRIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= pwdata[FWIDTH_BITS-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= pwdata[HEIGHT_BITS-1:0];
                REG_DARK_LEVEL:   cfg_reg.dark_level   <= pwdata[PIXEL_BITS-1:0];
                REG_BRIGHT_LEVEL: cfg_reg.bright_level <= pwdata[PIXEL_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_FRAME_WIDTH:  prdata = DATA_BITS'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = DATA_BITS'(cfg_reg.frame_height);
            REG_DARK_LEVEL:   prdata = DATA_BITS'(cfg_reg.dark_level);
            REG_BRIGHT_LEVEL: prdata = DATA_BITS'(cfg_reg.bright_level);
        endcase
    end

endmodule

// ----- rtl/inmf_line_buf.sv -----
// Two line memories (rows r-1 and r-2) with registered read and write-through bypass.
module inmf_line_buf
    import inmf_pkg::*;
#(
    parameter int DEPTH = 2048
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [PIXEL_BITS-1:0]    wr_pix,
    output logic [PIXEL_BITS-1:0]    up1,
    output logic [PIXEL_BITS-1:0]    up2
);

    logic [PIXEL_BITS-1:0] line1_mem [DEPTH];
    logic [PIXEL_BITS-1:0] line2_mem [DEPTH];
    logic [PIXEL_BITS-1:0] rd1_reg;
    logic [PIXEL_BITS-1:0] rd2_reg;
    logic [PIXEL_BITS-1:0] byp1_reg;
    logic [PIXEL_BITS-1:0] byp2_reg;
    logic                  byp_sel_reg;

    // row r-1 moves down to r-2 as the new pixel lands in r-1
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line1_mem[wr_addr] <= wr_pix;
            line2_mem[wr_addr] <= up1;
        end
        if (rd_en)
        begin
            rd1_reg  <= line1_mem[rd_addr];
            rd2_reg  <= line2_mem[rd_addr];
            byp1_reg <= wr_pix;
            byp2_reg <= up1;
        end
    end

    // same-address read and write in one cycle: take the word being written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            byp_sel_reg <= 1'b0;
        else if (rd_en)
            byp_sel_reg <= wr_en && (wr_addr == rd_addr);
    end

    assign up1 = byp_sel_reg ? byp1_reg : rd1_reg;
    assign up2 = byp_sel_reg ? byp2_reg : rd2_reg;

endmodule

// ----- rtl/inmf_window.sv -----
// 3x3 window registers and the impulse test with eight-neighbor mean.
module inmf_window
    import inmf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift_en,
    input  logic [PIXEL_BITS-1:0] up2,
    input  logic [PIXEL_BITS-1:0] up1,
    input  logic [PIXEL_BITS-1:0] pix,
    input  logic [PIXEL_BITS-1:0] dark_level,
    input  logic [PIXEL_BITS-1:0] bright_level,
    output logic [PIXEL_BITS-1:0] res_pix,
    output logic                  res_rep
);

    // index row*3 + col; row 0 oldest line, col 2 newest column
    logic [PIXEL_BITS-1:0] win_reg  [9];
    logic [PIXEL_BITS-1:0] win_next [9];
    logic [SUM_BITS-1:0]   sum;
    logic [PIXEL_BITS-1:0] centre;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k*3]     = win_reg[k*3 + 1];
            win_next[k*3 + 1] = win_reg[k*3 + 2];
        end
        win_next[2] = up2;
        win_next[5] = up1;
        win_next[8] = pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= '0;
        end
        else if (shift_en)
        begin
            for (int k = 0; k < 9; k++)
                win_reg[k] <= win_next[k];
        end
    end

    assign centre = win_next[4];

    always_comb
    begin
        sum = (SUM_BITS'(win_next[0]) + SUM_BITS'(win_next[1]))
            + (SUM_BITS'(win_next[2]) + SUM_BITS'(win_next[3]))
            + (SUM_BITS'(win_next[5]) + SUM_BITS'(win_next[6]))
            + (SUM_BITS'(win_next[7]) + SUM_BITS'(win_next[8]));
        res_rep = (centre == dark_level) || (centre == bright_level);
        res_pix = res_rep ? sum[SUM_BITS-1:3] : centre;
    end

endmodule

// ----- rtl/impulse_noise_neighbor_mean_filter.sv -----
// Top level of the impulse-noise 3x3 neighbor-mean filter.
//
// Takes a raster stream of pixels, one word per clock while pix_stall is
// low, and returns one word for each interior pixel of the frame: its
// value unchanged, or, when it equals dark_level or bright_level, the
// truncated mean of its eight neighbors (replaced set). frame_last marks
// the last interior pixel. The pixel at (r, c) releases the result for
// (r-1, c-1); border pixels give no word. frame_start puts a pixel at row
// 0, column 0; counters also wrap on their own at the end of a frame.
// Throughput is one pixel per clock while no result word is held; the
// input stage (pixel register and registered read port of the line
// memories) feeds the window and adder logic straight into the result
// register, which drives res_valid. A held result word stops the whole
// pipe and raises pix_stall. The line memories are not cleared after reset
// and hold garbage until written; results never depend on unwritten
// entries unless the frame size changes in the middle of a frame. Frame
// width is clamped to [3, MAX_WIDTH] and height to [3, 4096]. Registers:
// 0 frame_width, 1 frame_height, 2 dark_level, 3 bright_level, at byte
// addresses 0, 4, 8, 12; write them only while the block is idle.
module impulse_noise_neighbor_mean_filter
    import inmf_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  in_word_t             pix_word,
    output logic                 res_valid,
    input  logic                 res_stall,
    output out_word_t            res_word
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    cfg_t                  cfg;
    logic [WW-1:0]         w_use;
    logic [HEIGHT_BITS-1:0] h_use;

    // position counters
    logic [CW-1:0]         col_reg, col_next;
    logic [ROW_BITS-1:0]   row_reg, row_next;
    logic [CW-1:0]         col_cur;
    logic [ROW_BITS-1:0]   row_cur;

    // input stage: pixel waiting for its line-memory read
    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [ROW_BITS-1:0]   s1_row_reg;

    logic                  advance;
    logic                  accept;
    logic                  s1_fire;
    logic                  interior;
    logic                  last_pix;
    logic [PIXEL_BITS-1:0] up1, up2;
    logic [PIXEL_BITS-1:0] res_pix;
    logic                  res_rep;

    logic                  res_valid_reg;
    out_word_t             res_word_reg;

    inmf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // size clamps
    always_comb
    begin
        priority if (32'(cfg.frame_width) < MIN_SIZE)
            w_use = WW'(MIN_SIZE);
        else if (32'(cfg.frame_width) > MAX_WIDTH)
            w_use = WW'(MAX_WIDTH);
        else
            w_use = WW'(cfg.frame_width);

        priority if (32'(cfg.frame_height) < MIN_SIZE)
            h_use = HEIGHT_BITS'(MIN_SIZE);
        else if (32'(cfg.frame_height) > MAX_HEIGHT)
            h_use = HEIGHT_BITS'(MAX_HEIGHT);
        else
            h_use = cfg.frame_height;
    end

    // whole pipe moves when the result register is free
    assign advance   = !(res_valid_reg && res_stall);
    assign pix_stall = !advance;
    assign accept    = pix_valid && advance;
    assign s1_fire   = s1_valid_reg && advance;

    // position of the incoming pixel and the position after it
    always_comb
    begin
        col_cur = pix_word.frame_start ? '0 : col_reg;
        row_cur = pix_word.frame_start ? '0 : row_reg;
        if (32'(col_cur) + 1 >= 32'(w_use))
        begin
            col_next = '0;
            if (32'(row_cur) + 1 >= 32'(h_use))
                row_next = '0;
            else
                row_next = row_cur + ROW_BITS'(1);
        end
        else
        begin
            col_next = col_cur + CW'(1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= pix_valid;
            if (pix_valid)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= pix_word.pixel_in;
            s1_col_reg <= col_cur;
            s1_row_reg <= row_cur;
        end
    end

    // read at accept, write back when the pixel leaves the input stage
    inmf_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_pix  (s1_pix_reg),
        .up1     (up1),
        .up2     (up2)
    );

    inmf_window u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .shift_en     (s1_fire),
        .up2          (up2),
        .up1          (up1),
        .pix          (s1_pix_reg),
        .dark_level   (cfg.dark_level),
        .bright_level (cfg.bright_level),
        .res_pix      (res_pix),
        .res_rep      (res_rep)
    );

    // interior test and last-pixel flag for the pixel in the input stage
    always_comb
    begin
        interior = (32'(s1_row_reg) >= 2) && (32'(s1_col_reg) >= 2)
                && (32'(s1_row_reg) < 32'(h_use)) && (32'(s1_col_reg) < 32'(w_use));
        last_pix = (32'(s1_row_reg) == 32'(h_use) - 1)
                && (32'(s1_col_reg) == 32'(w_use) - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= s1_valid_reg && interior;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            res_word_reg.pixel_out  <= res_pix;
            res_word_reg.replaced   <= res_rep;
            res_word_reg.frame_last <= last_pix;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule
